// ===== src/assert_macros.svh =====
// Assertion macros used by the flow table controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/fwa_pkg.sv =====
// Package for the flow table: constants, payload structs, controller types.
// No dependencies.
`timescale 1ns / 1ps
package fwa_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 48;
    localparam int SUM_BITS    = 32;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_BITS    = 7;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic       CFG_LIMIT   = 1'b0;
    localparam logic       CFG_SHOWALL = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [47:0] src_key;
        logic [47:0] dst_key;
        logic [19:0] size_kb;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [47:0] flow_src;
        logic [47:0] flow_dst;
        logic [31:0] delta_kb;
        logic [31:0] total_kb;
        logic [5:0]  rank;
        logic [6:0]  entry_count;
        logic        last;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_REC_RD, S_REC_WR, S_REC_OUT,
        S_PICK, S_EMIT_RD, S_EMIT_OUT, S_EMPTY_OUT, S_CLEAR
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic rec_read;
        logic rec_write;
        logic rec_out;
        logic pick_start;
        logic pick_step;
        logic emit_read;
        logic emit_out;
        logic empty_out;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic scan_done;
        logic hit;
        logic has_free;
        logic pick_done;
        logic emit_more;
        logic emit_zero;
        logic out_busy;
    } sts_t;
endpackage

// ===== src/fwa_ctrl.sv =====
// Controller state machine for the flow table.
// Depends on fwa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fwa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  fwa_pkg::sts_t sts,
    output fwa_pkg::cmd_t cmd
);
    import fwa_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_SCAN;
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = sts.mode ? S_PICK : S_REC_RD;
            end
            S_REC_RD:    state_next = S_REC_WR;
            S_REC_WR:    state_next = S_REC_OUT;
            S_REC_OUT:   if (!sts.out_busy) state_next = S_IDLE;
            S_PICK:
            begin
                if (sts.pick_done)
                    state_next = sts.emit_zero ? S_EMPTY_OUT : S_EMIT_RD;
            end
            S_EMIT_RD:   state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (!sts.out_busy)
                    state_next = sts.emit_more ? S_PICK : S_CLEAR;
            end
            S_EMPTY_OUT: if (!sts.out_busy) state_next = S_CLEAR;
            S_CLEAR:     state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
                cmd.scan_start = in_valid;
            end
            S_SCAN:      cmd.scan_step = 1'b1;
            S_REC_RD:    cmd.rec_read = 1'b1;
            S_REC_WR:    cmd.rec_write = 1'b1;
            S_REC_OUT:   cmd.rec_out = !sts.out_busy;
            S_PICK:      cmd.pick_step = 1'b1;
            S_EMIT_RD:   cmd.emit_read = 1'b1;
            S_EMIT_OUT:
            begin
                cmd.emit_out = !sts.out_busy;
                cmd.pick_start = !sts.out_busy && sts.emit_more;
            end
            S_EMPTY_OUT: cmd.empty_out = !sts.out_busy;
            S_CLEAR:     cmd.clear = 1'b1;
            default:     cmd = '0;
        endcase
    end

    `ASSERT_IMPL(a_load_idle, clk, rst_n, cmd.load, state_reg == S_IDLE, "load outside idle")
    `ASSERT_NEXT(a_scan_after_load, clk, rst_n, cmd.load, state_reg == S_SCAN, "no scan")
    `ASSERT_IMPL(a_out_free, clk, rst_n, cmd.emit_out || cmd.rec_out || cmd.empty_out,
        !sts.out_busy, "output overwritten")
endmodule

// ===== src/fwa_datapath.sv =====
// Datapath: entry store, match scan, ranking selection and output register.
// Depends on fwa_pkg.
`timescale 1ns / 1ps
module fwa_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  fwa_pkg::in_beat_t  in_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    input  fwa_pkg::cmd_t      cmd,
    output fwa_pkg::sts_t      sts,
    output logic               out_valid,
    input  logic               out_stall,
    output fwa_pkg::out_beat_t out_data
);
    import fwa_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] stale_reg, stale_next;
    logic [TABLE_DEPTH-1:0] done_reg;
    logic [KEY_BITS-1:0] src_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] dst_mem [TABLE_DEPTH];
    logic [SUM_BITS-1:0] tot_mem [TABLE_DEPTH];
    logic [SUM_BITS-1:0] dlt_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] src_rd_reg, dst_rd_reg;
    logic [SUM_BITS-1:0] tot_rd_reg, dlt_rd_reg, dlt_rd;
    logic stale_rd_reg;
    logic rd_en, issue;
    logic [IDX_BITS-1:0] rd_addr;
    logic cmp_live_reg;
    logic [IDX_BITS-1:0] cmp_idx_reg;

    in_beat_t item_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [6:0] limit_reg;
    logic show_all_reg;
    logic [CNT_BITS-1:0] step_reg;
    logic [IDX_BITS-1:0] step_idx;
    logic hit_reg, free_found_reg;
    logic [IDX_BITS-1:0] hit_idx_reg, free_idx_reg;
    logic best_found_reg;
    logic [IDX_BITS-1:0] best_idx_reg;
    logic [SUM_BITS-1:0] best_dlt_reg, best_tot_reg;
    logic [CNT_BITS-1:0] emitted_reg, emit_total;
    logic [IDX_BITS-1:0] wr_idx;
    logic [SUM_BITS-1:0] new_tot, new_dlt;
    logic out_valid_reg;
    out_beat_t out_reg;
    logic better;

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [19:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + (SUM_BITS+1)'(b);
        return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endfunction

    assign step_idx = step_reg[IDX_BITS-1:0];
    // deltas cleared by a dump read as zero until the entry is next written
    assign dlt_rd = stale_rd_reg ? '0 : dlt_rd_reg;
    assign better = !best_found_reg || (dlt_rd > best_dlt_reg)
        || (dlt_rd == best_dlt_reg && tot_rd_reg > best_tot_reg);

    always_comb
    begin
        emit_total = count_reg;
        if (!show_all_reg && CNT_BITS'(limit_reg) < count_reg)
            emit_total = CNT_BITS'(limit_reg);
    end

    assign wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    assign new_tot = sat_add(hit_reg ? tot_rd_reg : '0, item_reg.size_kb);
    assign new_dlt = sat_add(hit_reg ? dlt_rd : '0, item_reg.size_kb);

    // one slot read per cycle; each read is registered and compared from the read registers
    assign issue = ((cmd.scan_step && !item_reg.mode) || cmd.pick_step)
        && step_reg != CNT_BITS'(TABLE_DEPTH);
    assign rd_en = issue || cmd.rec_read || cmd.emit_read;

    always_comb
    begin
        if (cmd.rec_read)
            rd_addr = wr_idx;
        else if (cmd.emit_read)
            rd_addr = best_idx_reg;
        else
            rd_addr = step_idx;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (rd_en)
        begin
            src_rd_reg <= src_mem[rd_addr];
            dst_rd_reg <= dst_mem[rd_addr];
            tot_rd_reg <= tot_mem[rd_addr];
            dlt_rd_reg <= dlt_mem[rd_addr];
        end
        if (cmd.rec_write && (hit_reg || free_found_reg))
        begin
            src_mem[wr_idx] <= item_reg.src_key;
            dst_mem[wr_idx] <= item_reg.dst_key;
            tot_mem[wr_idx] <= new_tot;
            dlt_mem[wr_idx] <= new_dlt;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.rec_write && !hit_reg && free_found_reg)
            valid_next[free_idx_reg] = 1'b1;
    end

    always_comb
    begin
        stale_next = stale_reg;
        if (cmd.clear)
            stale_next = '1;
        else if (cmd.rec_write && (hit_reg || free_found_reg))
            stale_next[wr_idx] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            stale_reg <= '1;
            stale_rd_reg <= 1'b1;
            cmp_live_reg <= 1'b0;
            cmp_idx_reg <= '0;
            count_reg <= '0;
            limit_reg <= 7'd21;
            show_all_reg <= 1'b0;
            step_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
            done_reg <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg <= '0;
            best_dlt_reg <= '0;
            best_tot_reg <= '0;
            emitted_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            stale_reg <= stale_next;
            if (rd_en)
                stale_rd_reg <= stale_reg[rd_addr];
            if (cfg_we)
            begin
                if (cfg_index == CFG_LIMIT)
                    limit_reg <= cfg_data;
                else
                    show_all_reg <= cfg_data[0];
            end
            if (cmd.rec_write && !hit_reg && free_found_reg)
                count_reg <= count_reg + 1'b1;
            if (cmd.scan_start)
            begin
                step_reg <= '0;
                hit_reg <= 1'b0;
                free_found_reg <= 1'b0;
                done_reg <= '0;
                emitted_reg <= '0;
                best_found_reg <= 1'b0;
                cmp_live_reg <= 1'b0;
            end
            else if (cmd.pick_start)
            begin
                step_reg <= '0;
                best_found_reg <= 1'b0;
                cmp_live_reg <= 1'b0;
            end
            else
            begin
                cmp_live_reg <= issue;
                if (issue)
                begin
                    step_reg <= step_reg + 1'b1;
                    cmp_idx_reg <= step_idx;
                end
                if (cmp_live_reg && cmd.scan_step && !item_reg.mode)
                begin
                    if (valid_reg[cmp_idx_reg])
                    begin
                        if (!hit_reg && src_rd_reg == item_reg.src_key
                            && dst_rd_reg == item_reg.dst_key)
                        begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= cmp_idx_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg <= cmp_idx_reg;
                    end
                end
                if (cmp_live_reg && cmd.pick_step && valid_reg[cmp_idx_reg]
                    && !done_reg[cmp_idx_reg] && better)
                begin
                    best_found_reg <= 1'b1;
                    best_idx_reg <= cmp_idx_reg;
                    best_dlt_reg <= dlt_rd;
                    best_tot_reg <= tot_rd_reg;
                end
            end
            if (cmd.emit_read)
                done_reg[best_idx_reg] <= 1'b1;
            if (cmd.emit_out)
                emitted_reg <= emitted_reg + 1'b1;
            if (cmd.rec_out || cmd.emit_out || cmd.empty_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rec_out)
        begin
            out_reg <= '0;
            out_reg.kind <= KIND_RECORD;
            out_reg.flow_src <= item_reg.src_key;
            out_reg.flow_dst <= item_reg.dst_key;
            out_reg.entry_count <= count_reg;
            out_reg.last <= 1'b1;
            if (hit_reg || free_found_reg)
            begin
                out_reg.status <= hit_reg ? ST_UPDATED : ST_INSERTED;
                out_reg.delta_kb <= new_dlt;
                out_reg.total_kb <= new_tot;
            end
            else
                out_reg.status <= ST_OVERFLOW;
        end
        else if (cmd.emit_out)
        begin
            out_reg.kind <= KIND_ENTRY;
            out_reg.status <= ST_UPDATED;
            out_reg.flow_src <= src_rd_reg;
            out_reg.flow_dst <= dst_rd_reg;
            out_reg.delta_kb <= dlt_rd;
            out_reg.total_kb <= tot_rd_reg;
            out_reg.rank <= emitted_reg[IDX_BITS-1:0];
            out_reg.entry_count <= count_reg;
            out_reg.last <= (emitted_reg + 1'b1) == emit_total;
        end
        else if (cmd.empty_out)
        begin
            out_reg <= '0;
            out_reg.kind <= KIND_EMPTY;
            out_reg.entry_count <= count_reg;
            out_reg.last <= 1'b1;
        end
    end

    always_comb
    begin
        sts.mode = item_reg.mode;
        sts.scan_done = item_reg.mode
            || (cmp_live_reg && cmp_idx_reg == IDX_BITS'(TABLE_DEPTH - 1));
        sts.hit = hit_reg;
        sts.has_free = free_found_reg;
        sts.pick_done = cmp_live_reg && cmp_idx_reg == IDX_BITS'(TABLE_DEPTH - 1);
        sts.emit_more = (emitted_reg + 1'b1) < emit_total;
        sts.emit_zero = emit_total == '0;
        sts.out_busy = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
endmodule

// ===== src/flow_window_accumulator_topn.sv =====
// Flow table top: a record beat is taken, then runs a pipelined match scan over all
// entries, a read, a write and the output register; the next beat is taken after that.
// A dump runs a selection pass over all entries for each result, then a read and the
// output register (an empty table, or a limit of zero without show-all, gives one empty beat), then clears the deltas.
// Output stalls hold the item back. One item at a time. rst_n clears valid bits, count and registers to defaults.
// Depends on fwa_pkg, fwa_ctrl and fwa_datapath.
`timescale 1ns / 1ps
module flow_window_accumulator_topn (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fwa_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output fwa_pkg::out_beat_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data
);
    import fwa_pkg::*;
    cmd_t cmd;
    sts_t sts;

    fwa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .sts(sts), .cmd(cmd)
    );

    fwa_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the flow table top: directed and random record/dump items, with a
// behavioural table predictor and a result checker. Depends on fwa_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
    import fwa_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_beat_t out_data;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_LIMIT;
    logic [6:0] cfg_data = '0;

    flow_window_accumulator_topn dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // predictor state
    bit          tbl_valid [TABLE_DEPTH];
    logic [47:0] tbl_src [TABLE_DEPTH];
    logic [47:0] tbl_dst [TABLE_DEPTH];
    logic [31:0] tbl_total [TABLE_DEPTH];
    logic [31:0] tbl_delta [TABLE_DEPTH];
    int          tbl_count = 0;
    int          pred_limit = 21;
    bit          pred_show_all = 1'b0;

    out_beat_t expected_beats[$];
    in_beat_t  send_q[$];
    int  queued_count = 0;
    int  accepted_count = 0;
    int  gap_left = -1;
    int  errors = 0;
    bit  hold_off = 1'b0;
    logic [47:0] key_pool [16];

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [19:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic bit outranks(int x, int y);
        if (tbl_delta[x] != tbl_delta[y]) return tbl_delta[x] > tbl_delta[y];
        if (tbl_total[x] != tbl_total[y]) return tbl_total[x] > tbl_total[y];
        return x < y;
    endfunction

    function automatic void predict_beat(in_beat_t b);
        out_beat_t r;
        int free_slot, n, emit, j;
        int order [TABLE_DEPTH];
        free_slot = -1;
        r = '0;
        if (b.mode == 1'b0) begin
            r.kind = KIND_RECORD;
            r.flow_src = b.src_key;
            r.flow_dst = b.dst_key;
            r.last = 1'b1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (tbl_valid[i]) begin
                    if (tbl_src[i] == b.src_key && tbl_dst[i] == b.dst_key) begin
                        tbl_total[i] = sat_sum(tbl_total[i], b.size_kb);
                        tbl_delta[i] = sat_sum(tbl_delta[i], b.size_kb);
                        r.status = ST_UPDATED;
                        r.delta_kb = tbl_delta[i];
                        r.total_kb = tbl_total[i];
                        r.entry_count = 7'(tbl_count);
                        expected_beats.push_back(r);
                        return;
                    end
                end
                else if (free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
                r.status = ST_OVERFLOW;
                r.entry_count = 7'(tbl_count);
            end
            else begin
                tbl_valid[free_slot] = 1'b1;
                tbl_src[free_slot] = b.src_key;
                tbl_dst[free_slot] = b.dst_key;
                tbl_total[free_slot] = {12'd0, b.size_kb};
                tbl_delta[free_slot] = {12'd0, b.size_kb};
                tbl_count++;
                r.status = ST_INSERTED;
                r.delta_kb = tbl_total[free_slot];
                r.total_kb = tbl_total[free_slot];
                r.entry_count = 7'(tbl_count);
            end
            expected_beats.push_back(r);
            return;
        end
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_valid[i]) begin
                j = n;
                while (j > 0 && outranks(i, order[j-1])) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
                n++;
            end
        end
        emit = n;
        if (!pred_show_all && pred_limit < emit) emit = pred_limit;
        if (emit == 0) begin
            r.kind = KIND_EMPTY;
            r.entry_count = 7'(tbl_count);
            r.last = 1'b1;
            expected_beats.push_back(r);
        end
        for (int k = 0; k < emit; k++) begin
            r = '0;
            r.kind = KIND_ENTRY;
            r.flow_src = tbl_src[order[k]];
            r.flow_dst = tbl_dst[order[k]];
            r.delta_kb = tbl_delta[order[k]];
            r.total_kb = tbl_total[order[k]];
            r.rank = 6'(k);
            r.entry_count = 7'(tbl_count);
            r.last = (k == emit - 1);
            expected_beats.push_back(r);
        end
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_delta[i] = '0;
    endfunction

    // sender: owns in_valid and in_data, predicts each beat as it is taken
    always @(posedge clk) begin
        bit offer;
        offer = 1'b0;
        if (in_valid && !in_stall) begin
            predict_beat(in_data);
            accepted_count++;
        end
        if (!in_valid || !in_stall) begin
            if (send_q.size() != 0) begin
                if (gap_left < 0) gap_left = $urandom_range(3);
                if (gap_left == 0) begin
                    offer = 1'b1;
                    in_data <= send_q.pop_front();
                    gap_left = -1;
                end
                else gap_left--;
            end
            in_valid <= offer;
        end
    end

    task automatic send_beat(in_beat_t b);
        int ticket;
        send_q.push_back(b);
        queued_count++;
        ticket = queued_count;
        wait (accepted_count >= ticket);
    endtask

    task automatic send_record(logic [47:0] s, logic [47:0] d, logic [19:0] sz);
        in_beat_t b;
        b.mode = 1'b0;
        b.src_key = s;
        b.dst_key = d;
        b.size_kb = sz;
        send_beat(b);
    endtask

    task automatic send_dump();
        in_beat_t b;
        b.mode = 1'b1;
        b.src_key = {$urandom(), 16'($urandom())};
        b.dst_key = {$urandom(), 16'($urandom())};
        b.size_kb = 20'($urandom());
        send_beat(b);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_beats.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LIMIT) pred_limit = val;
        else pred_show_all = val[0];
    endtask

    // result checker and receiver stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, out_data);
                errors++;
            end
            else begin
                out_beat_t e;
                e = expected_beats.pop_front();
                if (out_data.kind !== e.kind || out_data.status !== e.status
                    || out_data.flow_src !== e.flow_src || out_data.flow_dst !== e.flow_dst
                    || out_data.delta_kb !== e.delta_kb || out_data.total_kb !== e.total_kb
                    || out_data.rank !== e.rank || out_data.entry_count !== e.entry_count
                    || out_data.last !== e.last) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
                    errors++;
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        @(posedge clk);
        forever begin
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_cycles = ($urandom_range(3) == 0) ? 0 : $urandom_range(3);
            out_stall <= (wait_cycles != 0);
            repeat (wait_cycles + 1) @(posedge clk);
        end
    end

    task automatic test_empty_and_extremes();
        send_dump();
        send_record('0, '0, '0);
        send_record('1, '1, 20'hFFFFF);
        send_record('1, '1, 20'hFFFFF);
        send_record(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 20'h0);
        send_record(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 20'h5A5A5);
        send_dump();
        send_dump();
        write_reg(CFG_LIMIT, 7'd0);
        send_dump();
        write_reg(CFG_LIMIT, 7'd2);
        send_record('0, '0, 20'd7);
        send_dump();
    endtask

    task automatic test_fill_overflow();
        write_reg(CFG_SHOWALL, 7'd1);
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send_record({$urandom(), 16'(i)}, {16'(i), $urandom()}, 20'($urandom_range(50)));
        hold_off = 1'b1;
        send_dump();
        for (int i = 0; i < 6; i++) send_record('1, '0, 20'd1);
        send_dump();
    endtask

    task automatic test_random();
        int limits [4];
        limits = '{7'd1, 7'd64, 7'd127, 7'd5};
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom(), 16'($urandom())};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_LIMIT, 7'(limits[ph]));
            write_reg(CFG_SHOWALL, {6'd0, ph[0]});
            if (ph == 2) begin
                write_reg(CFG_LIMIT, 7'd64);
                drain();
            end
            for (int i = 0; i < 93; i++) begin
                int r;
                r = $urandom_range(99);
                if (r < 8) send_dump();
                else if (r < 18)
                    send_record({$urandom(), 16'($urandom())}, {$urandom(), 16'($urandom())},
                                20'($urandom()));
                else send_record(key_pool[$urandom_range(15)], key_pool[$urandom_range(15)],
                                 20'(($urandom_range(3) == 0) ? $urandom()
                                                               : $urandom_range(300)));
            end
            send_dump();
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_extremes();
        test_fill_overflow();
        test_random();
        drain();
        if (errors == 0 && expected_beats.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("testbench failed");
        $finish;
    end
endmodule

// ===== flow_window_accumulator_topn.f =====
+incdir+src
src/fwa_pkg.sv
src/fwa_ctrl.sv
src/fwa_datapath.sv
src/flow_window_accumulator_topn.sv
tb/sv/testbench.sv
